// ----- rtl/rcr_pkg.sv -----
// ----------------------------------------------------------------------------
// rcr_pkg
// Types, constants and the sensor weight table of the reflectance array reader.
// ----------------------------------------------------------------------------
package rcr_pkg;

    localparam int TIMER_BITS_DEF = 16;
    localparam int CFG_W          = 16;
    localparam int LEVEL_W        = 8;
    localparam int POS_W          = 10;
    localparam int SUM_W          = 11;
    localparam int BLK_W          = 4;
    localparam int STEP_W         = 4;
    localparam int REM_W          = 3;
    localparam int DIV_STEPS      = POS_W;
    localparam int OUT_DATA_W     = 24;

    localparam logic [CFG_W-1:0] CHARGE_RST = 16'd10;
    localparam logic [CFG_W-1:0] WAIT_RST   = 16'd1000;

    localparam logic CFG_CHARGE = 1'b0;
    localparam logic CFG_WAIT   = 1'b1;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    typedef logic signed [SUM_W-1:0] t_sum;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_CHARGE,
        PH_WAIT
    } t_phase;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_SUM,
        SEQ_ABS,
        SEQ_DIV,
        SEQ_SIGN
    } t_seq;

    // weight of one pin, indexed by bit position (bit 7 is the leftmost sensor)
    function automatic t_sum weight(input logic [2:0] bit_pos);
        t_sum w;
        unique case (bit_pos)
            3'd7:    w = 11'sd334;
            3'd6:    w = 11'sd238;
            3'd5:    w = 11'sd142;
            3'd4:    w = 11'sd48;
            3'd3:    w = -11'sd48;
            3'd2:    w = -11'sd142;
            3'd1:    w = -11'sd238;
            default: w = -11'sd334;
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/rc_reflectance_array_reader_top.sv -----
// ----------------------------------------------------------------------------
// rc_reflectance_array_reader_top
// Charge/wait/sample controller for an eight-channel RC reflectance array,
// with a line position worked out by one shared adder under a sequencer.
// ----------------------------------------------------------------------------
// Tick and start items: the result is registered in the cycle after the item is accepted.
// Sampling item: the result follows these steps (no divide steps with no black pin):
// 8 accumulate steps, 1 magnitude step, 10 restoring divide steps, 1 sign step,
// all on the one adder. One item at a time; ready is low until the result is taken.
// Reset (synchronous, active low): idle phase, timer and last reading/position
// cleared, charge time 10, wait time 1000.
module rc_reflectance_array_reader_top #(
    parameter int TIMER_BITS = rcr_pkg::TIMER_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic                              i_cfg_addr,
    input  logic [rcr_pkg::CFG_W-1:0]         i_cfg_data,
    // input items
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [rcr_pkg::LEVEL_W-1:0]       i_s_axis_tdata,  // [7:0] sensor_levels
    input  logic                              i_s_axis_tuser,  // [0] command
    // result items
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [0] led_on, [1] drive_pins, [2] busy_res, [10:3] reading, [20:11] position
    output logic [rcr_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    output logic                              o_m_axis_tuser   // [0] reading_valid
);

    localparam int CMP_W = (TIMER_BITS > rcr_pkg::CFG_W) ? TIMER_BITS : rcr_pkg::CFG_W;
    localparam logic [TIMER_BITS-1:0] TIMER_TOP = '1;
    localparam logic [rcr_pkg::STEP_W-1:0] SUM_LAST = 4'd7;
    localparam logic [rcr_pkg::STEP_W-1:0] DIV_LAST = rcr_pkg::STEP_W'(rcr_pkg::DIV_STEPS - 1);

    rcr_pkg::t_phase                 r_phase, n_phase;
    rcr_pkg::t_seq                   r_seq, n_seq;
    logic [TIMER_BITS-1:0]           r_tick, n_tick;
    logic [rcr_pkg::CFG_W-1:0]       r_charge, r_wait;
    logic [rcr_pkg::LEVEL_W-1:0]     r_last_reading, n_last_reading;
    logic [rcr_pkg::POS_W-1:0]       r_last_pos, n_last_pos;
    logic [rcr_pkg::LEVEL_W-1:0]     r_bits, n_bits;
    rcr_pkg::t_sum                   r_sum, n_sum;
    logic [rcr_pkg::BLK_W-1:0]       r_blk, n_blk;
    logic [rcr_pkg::STEP_W-1:0]      r_step, n_step;
    logic [rcr_pkg::POS_W-1:0]       r_dvd, n_dvd;
    logic [rcr_pkg::REM_W-1:0]       r_rem, n_rem;
    logic                            r_neg, n_neg;
    logic                            r_out_valid, n_out_valid;
    logic [rcr_pkg::OUT_DATA_W-1:0]  r_out_data, n_out_data;
    logic                            r_out_user, n_out_user;

    logic                            in_accept;
    logic                            is_start;
    logic [TIMER_BITS-1:0]           tick_inc;
    logic [rcr_pkg::CFG_W-1:0]       limit;
    logic                            phase_done;
    logic                            sample;
    rcr_pkg::t_sum                   alu_a, alu_b, alu_y;
    logic                            alu_sub;
    logic                            div_ge;
    logic [rcr_pkg::REM_W:0]         rem_sh;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_seq == rcr_pkg::SEQ_IDLE) && !r_out_valid;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    assign in_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign is_start  = (i_s_axis_tuser == rcr_pkg::CMD_START);

    // shared adder
    assign alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

    assign rem_sh = {r_rem, r_dvd[rcr_pkg::POS_W-1]};
    assign div_ge = !alu_y[rcr_pkg::SUM_W-1];

    // saturating tick counter and phase limit compare
    always_comb begin
        tick_inc   = (r_tick == TIMER_TOP) ? r_tick : r_tick + 1'b1;
        limit      = (r_phase == rcr_pkg::PH_CHARGE) ? r_charge : r_wait;
        phase_done = (CMP_W'(tick_inc) >= CMP_W'(limit)) || (tick_inc == TIMER_TOP);
        sample     = in_accept && !is_start && (r_phase == rcr_pkg::PH_WAIT) && phase_done;
    end

    // phase and sequencer next state
    always_comb begin
        n_phase = r_phase;
        n_seq   = r_seq;
        if (in_accept) begin
            if (is_start) begin
                if (r_phase == rcr_pkg::PH_IDLE) begin
                    n_phase = rcr_pkg::PH_CHARGE;
                end
            end else begin
                unique case (r_phase)
                    rcr_pkg::PH_CHARGE: if (phase_done) n_phase = rcr_pkg::PH_WAIT;
                    rcr_pkg::PH_WAIT:   if (phase_done) n_phase = rcr_pkg::PH_IDLE;
                    default:            n_phase = rcr_pkg::PH_IDLE;
                endcase
            end
        end
        unique case (r_seq)
            rcr_pkg::SEQ_IDLE: if (sample) n_seq = rcr_pkg::SEQ_SUM;
            rcr_pkg::SEQ_SUM:  if (r_step == SUM_LAST) n_seq = rcr_pkg::SEQ_ABS;
            rcr_pkg::SEQ_ABS:  n_seq = (r_blk == '0) ? rcr_pkg::SEQ_SIGN : rcr_pkg::SEQ_DIV;
            rcr_pkg::SEQ_DIV:  if (r_step == DIV_LAST) n_seq = rcr_pkg::SEQ_SIGN;
            rcr_pkg::SEQ_SIGN: n_seq = rcr_pkg::SEQ_IDLE;
            default:           n_seq = rcr_pkg::SEQ_IDLE;
        endcase
    end

    // datapath and result register
    always_comb begin
        n_tick         = r_tick;
        n_last_reading = r_last_reading;
        n_last_pos     = r_last_pos;
        n_bits         = r_bits;
        n_sum          = r_sum;
        n_blk          = r_blk;
        n_step         = r_step;
        n_dvd          = r_dvd;
        n_rem          = r_rem;
        n_neg          = r_neg;
        n_out_valid    = r_out_valid && !i_m_axis_tready;
        n_out_data     = r_out_data;
        n_out_user     = r_out_user;
        alu_a          = '0;
        alu_b          = '0;
        alu_sub        = 1'b0;

        if (in_accept) begin
            if (is_start) begin
                if (r_phase == rcr_pkg::PH_IDLE) begin
                    n_tick = '0;
                end
            end else if (r_phase != rcr_pkg::PH_IDLE) begin
                n_tick = phase_done ? '0 : tick_inc;
            end
            if (sample) begin
                n_last_reading = i_s_axis_tdata;
                n_bits         = i_s_axis_tdata;
                n_sum          = '0;
                n_blk          = '0;
                n_step         = '0;
            end else begin
                n_out_valid = 1'b1;
                n_out_user  = 1'b0;
                n_out_data  = {3'b000, r_last_pos, r_last_reading,
                               n_phase != rcr_pkg::PH_IDLE,
                               n_phase == rcr_pkg::PH_CHARGE,
                               n_phase != rcr_pkg::PH_IDLE};
            end
        end

        unique case (r_seq)
            rcr_pkg::SEQ_SUM: begin
                alu_a  = r_sum;
                alu_b  = rcr_pkg::weight(r_step[2:0]);
                n_step = r_step + 1'b1;
                if (r_bits[r_step[2:0]]) begin
                    n_sum = alu_y;
                    n_blk = r_blk + 1'b1;
                end
            end
            rcr_pkg::SEQ_ABS: begin
                alu_b   = r_sum;
                alu_sub = r_sum[rcr_pkg::SUM_W-1];
                n_neg   = r_sum[rcr_pkg::SUM_W-1];
                n_dvd   = (r_blk == '0) ? '0 : alu_y[rcr_pkg::POS_W-1:0];
                n_rem   = '0;
                n_step  = '0;
            end
            rcr_pkg::SEQ_DIV: begin
                alu_a   = rcr_pkg::SUM_W'(rem_sh);
                alu_b   = rcr_pkg::SUM_W'(r_blk);
                alu_sub = 1'b1;
                n_rem   = div_ge ? alu_y[rcr_pkg::REM_W-1:0] : rem_sh[rcr_pkg::REM_W-1:0];
                n_dvd   = {r_dvd[rcr_pkg::POS_W-2:0], div_ge};
                n_step  = r_step + 1'b1;
            end
            rcr_pkg::SEQ_SIGN: begin
                alu_b       = rcr_pkg::SUM_W'(r_dvd);
                alu_sub     = r_neg;
                n_last_pos  = alu_y[rcr_pkg::POS_W-1:0];
                n_out_valid = 1'b1;
                n_out_user  = 1'b1;
                n_out_data  = {3'b000, alu_y[rcr_pkg::POS_W-1:0], r_last_reading,
                               1'b0, 1'b0, 1'b0};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= rcr_pkg::PH_IDLE;
            r_seq          <= rcr_pkg::SEQ_IDLE;
            r_tick         <= '0;
            r_charge       <= rcr_pkg::CHARGE_RST;
            r_wait         <= rcr_pkg::WAIT_RST;
            r_last_reading <= '0;
            r_last_pos     <= '0;
            r_blk          <= '0;
            r_step         <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_phase        <= n_phase;
            r_seq          <= n_seq;
            r_tick         <= n_tick;
            r_last_reading <= n_last_reading;
            r_last_pos     <= n_last_pos;
            r_blk          <= n_blk;
            r_step         <= n_step;
            r_out_valid    <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_addr)
                    rcr_pkg::CFG_CHARGE: r_charge <= i_cfg_data;
                    rcr_pkg::CFG_WAIT:   r_wait   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bits     <= n_bits;
        r_sum      <= n_sum;
        r_dvd      <= n_dvd;
        r_rem      <= n_rem;
        r_neg      <= n_neg;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
    end

    a_no_result_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq != rcr_pkg::SEQ_IDLE) |-> !r_out_valid)
        else $error("result pending while sequencer busy");

    a_drive_needs_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!r_out_data[1] || r_out_data[0]))
        else $error("pins driven with LEDs off");

    a_sample_ends_reading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_user) |-> (!r_out_data[2] && r_phase == rcr_pkg::PH_IDLE))
        else $error("sample reported while still busy");

    a_black_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq == rcr_pkg::SEQ_SIGN) |-> (r_blk <= 4'd8))
        else $error("black count out of range");

endmodule

// ----- tb/tb_rc_reflectance_array_reader_top.sv -----
// ----------------------------------------------------------------------------
// tb_rc_reflectance_array_reader_top
// Drives start and tick items into the reflectance array reader. A tracker
// class mirrors the charge/wait/sample sequence and the line centroid, and
// checks every result item field by field. Directed readings come first, the
// first one with the reset charge time and a wait time shortened part way
// through. Random items follow under several sender idle and receiver stall
// settings.
// ----------------------------------------------------------------------------
module tb_rc_reflectance_array_reader_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rcr_pkg::*;

    localparam int unsigned TIMER_TOP = (1 << TIMER_BITS_DEF) - 1;

    typedef struct packed {
        logic              led_on;
        logic              drive_pins;
        logic              busy;
        logic              sampled;
        logic [LEVEL_W-1:0] reading;
        logic [POS_W-1:0]   position;
    } t_reading;

    class sensor_reading_tracker;
        logic [CFG_W-1:0]   charge_ticks;
        logic [CFG_W-1:0]   settle_ticks;
        t_phase             phase;
        int unsigned        tick_count;
        logic [LEVEL_W-1:0] last_reading;
        logic [POS_W-1:0]   last_position;
        t_reading           pending_readings[$];
        int                 fail_count;

        function new();
            charge_ticks  = CHARGE_RST;
            settle_ticks  = WAIT_RST;
            phase         = PH_IDLE;
            tick_count    = 0;
            last_reading  = '0;
            last_position = '0;
            fail_count    = 0;
        endfunction

        function void write_reg(logic addr, logic [CFG_W-1:0] val);
            if (addr == CFG_CHARGE) begin
                charge_ticks = val;
            end else begin
                settle_ticks = val;
            end
        endfunction

        function bit advance_tick(int unsigned limit);
            if (tick_count < TIMER_TOP) begin
                tick_count++;
            end
            return (tick_count >= limit) || (tick_count >= TIMER_TOP);
        endfunction

        function int pin_weight(int pin);
            case (pin)
                7:       return 334;
                6:       return 238;
                5:       return 142;
                4:       return 48;
                3:       return -48;
                2:       return -142;
                1:       return -238;
                default: return -334;
            endcase
        endfunction

        function logic [POS_W-1:0] centroid(logic [LEVEL_W-1:0] bits);
            int sum;
            int cnt;
            sum = 0;
            cnt = 0;
            for (int i = 0; i < LEVEL_W; i++) begin
                if (bits[i]) begin
                    sum += pin_weight(i);
                    cnt++;
                end
            end
            if (cnt == 0) begin
                return '0;
            end
            return POS_W'(sum / cnt);
        endfunction

        // returns 1 when the item changes the state
        function bit note_item(logic cmd, logic [LEVEL_W-1:0] levels);
            bit       effective;
            bit       sampled;
            t_reading r;
            effective = 1'b1;
            sampled   = 1'b0;
            if (cmd == CMD_START) begin
                if (phase == PH_IDLE) begin
                    phase      = PH_CHARGE;
                    tick_count = 0;
                end else begin
                    effective = 1'b0;
                end
            end else if (phase == PH_CHARGE) begin
                if (advance_tick(charge_ticks)) begin
                    phase      = PH_WAIT;
                    tick_count = 0;
                end
            end else if (phase == PH_WAIT) begin
                if (advance_tick(settle_ticks)) begin
                    last_reading  = levels;
                    last_position = centroid(levels);
                    phase         = PH_IDLE;
                    tick_count    = 0;
                    sampled       = 1'b1;
                end
            end else begin
                effective = 1'b0;
            end
            r.led_on     = (phase != PH_IDLE);
            r.drive_pins = (phase == PH_CHARGE);
            r.busy       = (phase != PH_IDLE);
            r.sampled    = sampled;
            r.reading    = last_reading;
            r.position   = last_position;
            pending_readings.push_back(r);
            return effective;
        endfunction

        function void match_field(string name, int want, int got);
            if (want != got) begin
                if (fail_count < 10) begin
                    $display("%0t: mismatch on %s: expected %0d, got %0d",
                             $realtime, name, want, got);
                end
                fail_count++;
            end
        endfunction

        function void check_reading(logic [OUT_DATA_W-1:0] data, logic user);
            t_reading want;
            if (pending_readings.size() == 0) begin
                if (fail_count < 10) begin
                    $display("%0t: result item with nothing expected: data %h user %b",
                             $realtime, data, user);
                end
                fail_count++;
                return;
            end
            want = pending_readings.pop_front();
            match_field("led_on", want.led_on, data[0]);
            match_field("drive_pins", want.drive_pins, data[1]);
            match_field("busy_res", want.busy, data[2]);
            match_field("reading", want.reading, data[10:3]);
            match_field("position", $signed(want.position), $signed(data[20:11]));
            match_field("reading_valid", want.sampled, user);
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic                  i_cfg_addr = CFG_CHARGE;
    logic [CFG_W-1:0]      i_cfg_data = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [LEVEL_W-1:0]    i_s_axis_tdata = '0;   // [7:0] sensor_levels
    logic                  i_s_axis_tuser = CMD_TICK; // [0] command
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    // [0] led_on, [1] drive_pins, [2] busy_res, [10:3] reading, [20:11] position
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  o_m_axis_tuser;        // [0] reading_valid

    int src_idle_pct = 0;
    int sink_stall_pct = 0;

    sensor_reading_tracker tracker;

    rc_reflectance_array_reader_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            tracker.check_reading(o_m_axis_tdata, o_m_axis_tuser);
        end
        i_m_axis_tready <= (sink_stall_pct == 0) || ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic send_item(input logic cmd, input logic [LEVEL_W-1:0] levels,
                             output bit counted);
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= cmd;
        i_s_axis_tdata  <= levels;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        counted = tracker.note_item(cmd, levels);
    endtask

    task automatic take_reading(input logic [LEVEL_W-1:0] levels);
        bit counted;
        send_item(CMD_START, levels, counted);
        while (tracker.phase != PH_IDLE) send_item(CMD_TICK, levels, counted);
    endtask

    task automatic wait_for_results();
        i_s_axis_tvalid <= 1'b0;
        while (tracker.pending_readings.size() != 0) @(posedge i_clk);
        repeat (24) @(posedge i_clk);
    endtask

    task automatic load_timing(input logic [CFG_W-1:0] charge,
                               input logic [CFG_W-1:0] settle);
        logic [CFG_W-1:0] vals [2];
        vals[0] = charge;
        vals[1] = settle;
        for (int k = 0; k < 2; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_addr  <= (k == 0) ? CFG_CHARGE : CFG_WAIT;
            i_cfg_data  <= vals[k];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            tracker.write_reg((k == 0) ? CFG_CHARGE : CFG_WAIT, vals[k]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int target);
        int  done;
        int  start_pct;
        bit  counted;
        done = 0;
        while (done < target) begin
            start_pct = (tracker.phase == PH_IDLE) ? 75 : 6;
            send_item(($urandom_range(99) < start_pct) ? CMD_START : CMD_TICK,
                      LEVEL_W'($urandom), counted);
            if (counted) begin
                done++;
            end
        end
    endtask

    initial begin
        int   src_tab [4];
        int   sink_tab [4];
        bit   counted;
        logic [LEVEL_W-1:0] patterns [7];
        src_tab  = '{0, 66, 0, 8};
        sink_tab = '{0, 0, 66, 8};
        patterns = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h18, 8'hE7, 8'h55};
        tracker  = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset timing: idle tick, start, start while busy, the full charge,
        // then shorten the wait part way through
        send_item(CMD_TICK, 8'hFF, counted);
        send_item(CMD_START, 8'h00, counted);
        send_item(CMD_START, 8'hFF, counted);
        while (tracker.phase == PH_CHARGE) send_item(CMD_TICK, 8'h3C, counted);
        repeat (20) send_item(CMD_TICK, 8'h3C, counted);
        wait_for_results();
        load_timing(CHARGE_RST, CFG_W'(30));
        while (tracker.phase != PH_IDLE) send_item(CMD_TICK, 8'h3C, counted);
        wait_for_results();

        // zero times: each phase ends on its first tick
        load_timing('0, '0);
        foreach (patterns[i]) take_reading(patterns[i]);
        send_item(CMD_START, 8'hAA, counted);
        send_item(CMD_TICK, 8'hAA, counted);
        send_item(CMD_START, 8'h0F, counted);
        send_item(CMD_TICK, 8'hAA, counted);
        send_item(CMD_TICK, 8'hF0, counted);
        wait_for_results();

        for (int p = 0; p < 4; p++) begin
            src_idle_pct   = src_tab[p];
            sink_stall_pct = sink_tab[p];
            load_timing((p == 0) ? CFG_W'(0) : CFG_W'($urandom_range(1, 5)),
                        CFG_W'($urandom_range(0, 7)));
            run_random(100);
            wait_for_results();
            load_timing(CFG_W'($urandom_range(0, 4)), CFG_W'($urandom_range(0, 6)));
            run_random(100);
            wait_for_results();
        end

        if (tracker.fail_count == 0) begin
            $display("PASS rc_reflectance_array_reader_top");
        end else begin
            $display("FAIL rc_reflectance_array_reader_top");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("FAIL rc_reflectance_array_reader_top");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/rcr_pkg.sv
rtl/rc_reflectance_array_reader_top.sv
tb/tb_rc_reflectance_array_reader_top.sv
